/* rtl/fshd_pkg.sv */
package fshd_pkg;

  // Defaults for the top level parameters
  localparam int unsigned FRAME_WORDS_DEF  = 2504;
  localparam int unsigned RING_DEPTH_DEF   = 4096;
  localparam int unsigned FIRST_MARGIN_DEF = 8;
  localparam int unsigned LAST_MARGIN_DEF  = 32;

  // Field widths
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned BUF_W       = 16;
  localparam int unsigned CUR_DAY_W   = 17;
  localparam int unsigned BYTE_OFS_W  = 18;
  localparam int unsigned FRAME_NUM_W = 15;
  localparam int unsigned SEC_W       = 18;
  localparam int unsigned DAY_W       = 18;
  localparam int unsigned MJD_W       = 11;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 17;

  localparam logic [WORD_W-1:0] SYNC_WORD = 32'hABADDEED;

  localparam logic [BUF_W-1:0]     BUF_WORDS_RST = 16'd25040;
  localparam logic [CUR_DAY_W-1:0] CUR_DAY_RST   = 17'd55000;

  // Day thousands: q = (n + 500) / 1000 via reciprocal multiply.
  // Exact for |n| < 2^18 since 544 * 2^18 < 2^28.
  localparam int unsigned   RECIP_W     = 19;
  localparam logic [18:0]   DAY_RECIP   = 19'd268436;
  localparam int unsigned   DAY_SHIFT   = 28;
  localparam int unsigned   DAY_Q_W     = 8;
  localparam logic [9:0]    DAY_SPAN    = 10'd1000;
  localparam logic [9:0]    DAY_ROUND   = 10'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEARCH_MODE  = 2'd0,
    CFG_BUFFER_WORDS = 2'd1,
    CFG_CURRENT_DAY  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              sync;
    logic [WORD_W-1:0] word;
  } ring_entry_t;

endpackage

/* rtl/fshd_if.sv */
interface fshd_word_if;
  import fshd_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_word;
  logic              last_word;

  modport source(output valid, data_word, last_word, input ready);
  modport sink(input valid, data_word, last_word, output ready);
endinterface

interface fshd_result_if;
  import fshd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    not_found;
  logic [BYTE_OFS_W-1:0]   byte_offset;
  logic [FRAME_NUM_W-1:0]  first_frame;
  logic [SEC_W-1:0]        seconds;
  logic signed [DAY_W-1:0] day_number;

  modport source(output valid, not_found, byte_offset, first_frame, seconds, day_number,
                 input ready);
  modport sink(input valid, not_found, byte_offset, first_frame, seconds, day_number,
               output ready);
endinterface

interface fshd_cfg_if;
  import fshd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] reg_data;

  modport source(output valid, reg_index, reg_data, input ready);
  modport sink(input valid, reg_index, reg_data, output ready);
endinterface

/* rtl/frame_sync_header_decoder_top.sv */
// Frame sync search and header decode. One 32-bit word is taken per clock while ready is
// high; each word is written into a ring memory and, in the same cycle, the entry
// FRAME_WORDS-2 words back is read, so the sync check and both header words of the
// candidate frame come from one read port plus a three-entry window. A buffer's result
// moves from the last-word stage through the two decode registers to an output register
// and is held there until taken. Input ready drops while three results sit in the last-word
// stage, the two decode registers and the output register together, so with results taken
// promptly long buffers stream at one word per cycle; back-to-back one-word buffers stall.
// The ring needs no clearing pass after reset: every entry that is checked was written
// earlier in the same buffer.
module frame_sync_header_decoder_top #(
  parameter int unsigned FRAME_WORDS  = fshd_pkg::FRAME_WORDS_DEF,
  parameter int unsigned RING_DEPTH   = fshd_pkg::RING_DEPTH_DEF,
  parameter int unsigned FIRST_MARGIN = fshd_pkg::FIRST_MARGIN_DEF,
  parameter int unsigned LAST_MARGIN  = fshd_pkg::LAST_MARGIN_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  fshd_cfg_if.sink      cfg_i,
  fshd_word_if.sink     word_i,
  fshd_result_if.source result_o
);
  import fshd_pkg::*;

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [AW-1:0] PTR_LAST = AW'(RING_DEPTH - 1);
  localparam logic [AW-1:0] RD_INIT =
    AW'((RING_DEPTH - ((FRAME_WORDS - 2) % RING_DEPTH)) % RING_DEPTH);
  // Same ring slot as the word being written
  localparam bit FWD_J0 = (FRAME_WORDS % RING_DEPTH) == 0;
  localparam bit FWD_J1 = ((FRAME_WORDS - 1) % RING_DEPTH) == 0;
  localparam bit FWD_J2 = ((FRAME_WORDS - 2) % RING_DEPTH) == 0;
  localparam logic [POS_W-1:0] FRAME_POS = POS_W'(FRAME_WORDS);
  localparam logic [POS_W-1:0] POS_MAX   = '1;
  localparam logic signed [17:0] FIRST_M = 18'(FIRST_MARGIN);
  localparam logic signed [17:0] LAST_M  = 18'(LAST_MARGIN);

  // Configuration
  logic                 mode_q;
  logic [BUF_W-1:0]     buf_words_q;
  logic [CUR_DAY_W-1:0] cur_day_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      buf_words_q <= BUF_WORDS_RST;
      cur_day_q   <= CUR_DAY_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        CFG_SEARCH_MODE:  mode_q      <= cfg_i.reg_data[0];
        CFG_BUFFER_WORDS: buf_words_q <= cfg_i.reg_data[BUF_W-1:0];
        CFG_CURRENT_DAY:  cur_day_q   <= cfg_i.reg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 0
  ring_entry_t ring_mem [RING_DEPTH];
  ring_entry_t rd_data_q;
  ring_entry_t wr_entry;

  logic [POS_W-1:0] pos_q;
  logic [AW-1:0]    wr_ptr_q;
  logic [AW-1:0]    rd_ptr_q;
  logic             prev_adv_q;
  logic             accept;
  logic [2:0]       pending;

  logic             s1_v_q;
  logic             s1_last_q;
  logic             s1_shift_q;
  logic [POS_W-1:0] s1_pos_q;
  ring_entry_t      s1_entry_q;

  logic r1_v_q, r2_v_q, out_v_q;

  assign pending = 3'({s1_v_q & s1_last_q}) + 3'(r1_v_q) + 3'(r2_v_q) + 3'(out_v_q);
  assign word_i.ready = pending < 3'd3;
  assign accept = word_i.valid && word_i.ready;

  assign wr_entry.sync = (word_i.data_word == SYNC_WORD);
  assign wr_entry.word = word_i.data_word;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring_mem[wr_ptr_q] <= wr_entry;
      rd_data_q          <= ring_mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= RD_INIT;
      prev_adv_q <= 1'b1;
      s1_v_q     <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_v_q <= accept;
      if (accept) begin
        s1_last_q <= word_i.last_word;
        if (word_i.last_word) begin
          pos_q      <= '0;
          wr_ptr_q   <= '0;
          rd_ptr_q   <= RD_INIT;
          prev_adv_q <= 1'b1;
        end else if (pos_q != POS_MAX) begin
          pos_q      <= pos_q + 1'b1;
          wr_ptr_q   <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
          rd_ptr_q   <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
          prev_adv_q <= 1'b1;
        end else begin
          prev_adv_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pos_q   <= pos_q;
      s1_entry_q <= wr_entry;
      // a saturated position repeats, so the window stays put
      s1_shift_q <= prev_adv_q;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // win_q holds entries j, j+1, j+2 of the previous word, j = pos - FRAME_WORDS
  ring_entry_t win_q [3];
  ring_entry_t x0, x1, x2;

  logic                 found_q, found_d;
  logic [POS_W-1:0]     fp_q, fp_d;
  logic [WORD_W-1:0]    hdr_lo_q, hdr_lo_d;
  logic [WORD_W-1:0]    hdr_hi_q, hdr_hi_d;
  logic signed [17:0]   lim;
  logic                 hit;

  always_comb begin
    x0 = s1_shift_q ? win_q[1] : win_q[0];
    x1 = s1_shift_q ? win_q[2] : win_q[1];
    x2 = FWD_J2 ? s1_entry_q : rd_data_q;
    if (FWD_J0) x0 = s1_entry_q;
    if (FWD_J1) x1 = s1_entry_q;
  end

  assign lim = $signed({2'b00, buf_words_q}) - (mode_q ? LAST_M : FIRST_M);
  assign hit = s1_entry_q.sync && x0.sync && (s1_pos_q >= FRAME_POS) &&
               ($signed({2'b00, s1_pos_q}) < lim);

  always_comb begin
    found_d  = found_q;
    fp_d     = fp_q;
    hdr_lo_d = hdr_lo_q;
    hdr_hi_d = hdr_hi_q;
    // last-pair mode picks up the header words as they stream past
    if (found_q && mode_q) begin
      if ({1'b0, s1_pos_q} == {1'b0, fp_q} + 17'd1) begin
        hdr_lo_d = s1_entry_q.word;
      end else if ({1'b0, s1_pos_q} == {1'b0, fp_q} + 17'd2) begin
        hdr_hi_d = s1_entry_q.word;
      end
    end
    if (hit) begin
      if (!mode_q) begin
        if (!found_q) begin
          found_d  = 1'b1;
          fp_d     = s1_pos_q - FRAME_POS;
          hdr_lo_d = x1.word;
          hdr_hi_d = x2.word;
        end
      end else begin
        found_d  = 1'b1;
        fp_d     = s1_pos_q;
        hdr_lo_d = '0;
        hdr_hi_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      win_q[0] <= x0;
      win_q[1] <= x1;
      win_q[2] <= x2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q  <= 1'b0;
      fp_q     <= '0;
      hdr_lo_q <= '0;
      hdr_hi_q <= '0;
    end else if (s1_v_q) begin
      if (s1_last_q) begin
        found_q  <= 1'b0;
        fp_q     <= '0;
        hdr_lo_q <= '0;
        hdr_hi_q <= '0;
      end else begin
        found_q  <= found_d;
        fp_q     <= fp_d;
        hdr_lo_q <= hdr_lo_d;
        hdr_hi_q <= hdr_hi_d;
      end
    end
  end

  // ---------------------------------------------------------------- result path
  logic out_free, r2_move, r2_free, r1_move, r1_load;

  assign out_free = !out_v_q || result_o.ready;
  assign r2_move  = r2_v_q && out_free;
  assign r2_free  = !r2_v_q || r2_move;
  assign r1_move  = r1_v_q && r2_free;
  assign r1_load  = s1_v_q && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q  <= 1'b0;
      r2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      r1_v_q  <= r1_load || (r1_v_q && !r1_move);
      r2_v_q  <= r1_move || (r2_v_q && !r2_move);
      out_v_q <= r2_move || (out_v_q && !result_o.ready);
    end
  end

  // r1: raw header of the chosen frame
  logic                   r1_found_q;
  logic [POS_W-1:0]       r1_fp_q;
  logic [FRAME_NUM_W-1:0] r1_ff_q;
  logic [WORD_W-1:0]      r1_hi_q;

  always_ff @(posedge clk_i) begin
    if (r1_load) begin
      r1_found_q <= found_d;
      r1_fp_q    <= fp_d;
      r1_ff_q    <= hdr_lo_d[FRAME_NUM_W-1:0];
      r1_hi_q    <= hdr_hi_d;
    end
  end

  // BCD decode and reciprocal multiply for the day thousands
  logic [SEC_W-1:0]          sec_val;
  logic [MJD_W-1:0]          mjd_val;
  logic signed [18:0]        day_n;
  logic                      day_neg;
  logic [17:0]               day_mag;
  logic [17+RECIP_W:0]       day_prod;

  assign sec_val = SEC_W'(r1_hi_q[3:0])
                 + SEC_W'(r1_hi_q[7:4])   * SEC_W'(10)
                 + SEC_W'(r1_hi_q[11:8])  * SEC_W'(100)
                 + SEC_W'(r1_hi_q[15:12]) * SEC_W'(1000)
                 + SEC_W'(r1_hi_q[19:16]) * SEC_W'(10000);
  assign mjd_val = MJD_W'(r1_hi_q[23:20])
                 + MJD_W'(r1_hi_q[27:24]) * MJD_W'(10)
                 + MJD_W'(r1_hi_q[31:28]) * MJD_W'(100);
  assign day_n   = $signed({2'b00, cur_day_q}) + $signed({9'b0, DAY_ROUND})
                 - $signed({8'b0, mjd_val});
  assign day_neg = day_n[18];
  assign day_mag = day_neg ? 18'(-day_n) : 18'(day_n);
  assign day_prod = (18+RECIP_W)'(day_mag) * (18+RECIP_W)'(DAY_RECIP);

  logic                   r2_found_q;
  logic [POS_W-1:0]       r2_fp_q;
  logic [FRAME_NUM_W-1:0] r2_ff_q;
  logic [SEC_W-1:0]       r2_sec_q;
  logic [MJD_W-1:0]       r2_mjd_q;
  logic                   r2_neg_q;
  logic [DAY_Q_W-1:0]     r2_q_q;

  always_ff @(posedge clk_i) begin
    if (r1_move) begin
      r2_found_q <= r1_found_q;
      r2_fp_q    <= r1_fp_q;
      r2_ff_q    <= r1_ff_q;
      r2_sec_q   <= sec_val;
      r2_mjd_q   <= mjd_val;
      r2_neg_q   <= day_neg;
      r2_q_q     <= day_prod[DAY_SHIFT +: DAY_Q_W];
    end
  end

  // Restore thousands, quotient truncated toward zero, then saturate
  logic [17:0]        day_ofs;
  logic signed [19:0] day_full;
  logic [DAY_W-1:0]   day_sat;

  assign day_ofs  = 18'(r2_q_q) * 18'(DAY_SPAN);
  assign day_full = r2_neg_q ? $signed({9'b0, r2_mjd_q}) - $signed({2'b00, day_ofs})
                             : $signed({9'b0, r2_mjd_q}) + $signed({2'b00, day_ofs});

  always_comb begin
    if (day_full > 20'sd131071) begin
      day_sat = 18'h1FFFF;
    end else if (day_full < -20'sd131072) begin
      day_sat = 18'h20000;
    end else begin
      day_sat = day_full[DAY_W-1:0];
    end
  end

  logic                   out_nf_q;
  logic [BYTE_OFS_W-1:0]  out_ofs_q;
  logic [FRAME_NUM_W-1:0] out_ff_q;
  logic [SEC_W-1:0]       out_sec_q;
  logic [DAY_W-1:0]       out_day_q;

  always_ff @(posedge clk_i) begin
    if (r2_move) begin
      out_nf_q  <= !r2_found_q;
      out_ofs_q <= r2_found_q ? {r2_fp_q, 2'b00} : '0;
      out_ff_q  <= r2_found_q ? r2_ff_q : '0;
      out_sec_q <= r2_found_q ? r2_sec_q : '0;
      out_day_q <= r2_found_q ? day_sat : '0;
    end
  end

  assign result_o.valid       = out_v_q;
  assign result_o.not_found   = out_nf_q;
  assign result_o.byte_offset = out_ofs_q;
  assign result_o.first_frame = out_ff_q;
  assign result_o.seconds     = out_sec_q;
  assign result_o.day_number  = $signed(out_day_q);

endmodule
